// ===== design/gtsf_pkg.sv =====
// Shared types and constants for the group tracking scroll follower.
// No dependencies; imported by the top level.
package gtsf_pkg;

    localparam int POS_W      = 16;
    localparam int SUM_W      = 20;
    localparam int CAM_W      = 19;
    localparam int CNT_W      = 4;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 12;
    localparam int TILE_W     = 7;
    localparam int MAP_W      = 19;
    localparam int DIST_W     = 17;
    localparam int DIFF_W     = 21;
    localparam int REM_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [DIST_W-1:0] DROP_X = 17'd350;
    localparam logic [DIST_W-1:0] DROP_Y = 17'd250;
    localparam logic [DIST_W-1:0] JOIN_X = 17'd300;
    localparam logic [DIST_W-1:0] JOIN_Y = 17'd200;

    localparam logic [MAP_W-1:0]  MAP_MAX = 19'd262143;

    localparam logic signed [DIFF_W-1:0] STEP_POS = 21'sd8;
    localparam logic signed [DIFF_W-1:0] STEP_NEG = -21'sd8;
    localparam logic signed [4:0]        STEP_MAX = 5'sd8;
    localparam logic signed [4:0]        STEP_MIN = -5'sd8;

    localparam logic [CFG_W-1:0]  RST_SCREEN_W = 12'd320;
    localparam logic [CFG_W-1:0]  RST_SCREEN_H = 12'd240;
    localparam logic [CFG_W-1:0]  RST_MAP_W    = 12'd20;
    localparam logic [CFG_W-1:0]  RST_MAP_H    = 12'd15;
    localparam logic [TILE_W-1:0] RST_TILE     = 7'd16;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_MAP   = 6'b000100,
        S_STEP  = 6'b001000,
        S_CLAMP = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_W     = 3'd0,
        CFG_SCREEN_H     = 3'd1,
        CFG_MAP_W        = 3'd2,
        CFG_MAP_H        = 3'd3,
        CFG_TILE         = 3'd4,
        CFG_TRACK_SINGLE = 3'd5
    } t_cfg_idx;

endpackage

// ===== design/group_tracking_scroll_follower.sv =====
// Scroll-offset follower top level: avatar group tracking, averaging and camera follow.
// Depends on gtsf_pkg.
//
// Avatar samples (func 0) are taken one per cycle and update the tracked set, sums and
// count in the cycle they are accepted. A frame item (func 1) runs a small sequencer:
// in group mode with at least one tracked avatar the average goes through one shared
// restoring divider, one quotient bit per cycle, x then y; then each axis passes in three
// steps through one shared follow unit (map size, step, clamp), and the S_DONE state
// loads the result register once the output side is free. The input side stalls while a
// frame item is in work; avatar samples are still taken while a finished result waits
// to be read.
module group_tracking_scroll_follower #(
    parameter int MAX_AVATARS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gtsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gtsf_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_func,
    input  logic [gtsf_pkg::IDX_W-1:0]       i_avatar_index,
    input  logic signed [gtsf_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [gtsf_pkg::POS_W-1:0] i_pos_y,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [gtsf_pkg::CAM_W-1:0] o_shift_x,
    output logic signed [gtsf_pkg::CAM_W-1:0] o_shift_y,
    output logic [gtsf_pkg::CNT_W-1:0]       o_tracked_count
);
    import gtsf_pkg::*;

    localparam int IDX_SPAN = 2 ** IDX_W;
    localparam int SLOTS    = (MAX_AVATARS < IDX_SPAN) ? MAX_AVATARS : IDX_SPAN;

    t_state r_state;

    logic [CFG_W-1:0]  r_screen_w, r_screen_h, r_map_w, r_map_h;
    logic [TILE_W-1:0] r_tile;
    logic              r_single;

    logic signed [POS_W-1:0] r_ref_x, r_ref_y;
    logic [SLOTS-1:0]        r_tracked, r_seen;
    logic signed [SUM_W-1:0] r_sum_x, r_sum_y;
    logic [CNT_W-1:0]        r_count;
    logic signed [CAM_W-1:0] r_cam_x, r_cam_y;

    logic                    r_axis;
    logic [SUM_W-1:0]        r_quo;
    logic [REM_W-1:0]        r_rem;
    logic [DIV_CNT_W-1:0]    r_bit;
    logic                    r_neg;
    logic signed [POS_W-1:0] r_pt_x, r_pt_y;
    logic [CNT_W-1:0]        r_frame_cnt;
    logic [MAP_W-1:0]        r_map;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [SUM_W-1:0] r_cand, r_hi;

    logic                    r_out_valid;
    logic signed [CAM_W-1:0] r_shift_x, r_shift_y;
    logic [CNT_W-1:0]        r_out_cnt;

    logic                    in_acc, out_free;
    logic [SLOTS-1:0]        sel;
    logic                    in_range, cur_t, seen_hit, n_t;
    logic signed [DIST_W-1:0] dx_s, dy_s;
    logic [DIST_W-1:0]       dx, dy;
    logic [SUM_W-1:0]        abs_sum_x, abs_sum_y;
    logic [REM_W:0]          div_t;
    logic                    div_ge;
    logic [REM_W:0]          div_sub;
    logic [SUM_W-1:0]        quo_next;
    logic [POS_W-1:0]        pt_div;
    logic [CFG_W-1:0]        ax_screen, ax_tiles;
    logic signed [CAM_W-1:0] ax_cam;
    logic signed [POS_W-1:0] ax_pt;
    logic [MAP_W-1:0]        map_prod, map_sat;
    logic signed [17:0]      target;
    logic signed [DIFF_W-1:0] diff_calc;
    logic signed [4:0]       step_cl;
    logic signed [SUM_W-1:0] hi_mag, small_cam;
    logic signed [CAM_W-1:0] cam_new;

    assign o_in_stall      = (r_state != S_IDLE);
    assign in_acc          = i_in_valid && (r_state == S_IDLE);
    assign out_free        = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_shift_x       = r_shift_x;
    assign o_shift_y       = r_shift_y;
    assign o_tracked_count = r_out_cnt;

    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            sel[j] = (i_avatar_index == IDX_W'(j));
        end
    end

    assign in_range = (32'(i_avatar_index) < MAX_AVATARS);
    assign cur_t    = |(sel & r_tracked);
    assign seen_hit = |(sel & r_seen);

    assign dx_s = {r_ref_x[POS_W-1], r_ref_x} - {i_pos_x[POS_W-1], i_pos_x};
    assign dy_s = {r_ref_y[POS_W-1], r_ref_y} - {i_pos_y[POS_W-1], i_pos_y};
    assign dx   = dx_s[DIST_W-1] ? DIST_W'(-dx_s) : DIST_W'(dx_s);
    assign dy   = dy_s[DIST_W-1] ? DIST_W'(-dy_s) : DIST_W'(dy_s);
    assign n_t  = cur_t ? !(dx > DROP_X || dy > DROP_Y) : (dx < JOIN_X && dy < JOIN_Y);

    assign abs_sum_x = r_sum_x[SUM_W-1] ? SUM_W'(-r_sum_x) : SUM_W'(r_sum_x);
    assign abs_sum_y = r_sum_y[SUM_W-1] ? SUM_W'(-r_sum_y) : SUM_W'(r_sum_y);

    assign div_t    = {r_rem, r_quo[SUM_W-1]};
    assign div_ge   = (div_t >= {1'b0, r_count});
    assign div_sub  = div_t - {1'b0, r_count};
    assign quo_next = {r_quo[SUM_W-2:0], div_ge};
    assign pt_div   = r_neg ? POS_W'(-quo_next) : quo_next[POS_W-1:0];

    assign ax_screen = r_axis ? r_screen_h : r_screen_w;
    assign ax_tiles  = r_axis ? r_map_h : r_map_w;
    assign ax_cam    = r_axis ? r_cam_y : r_cam_x;
    assign ax_pt     = r_axis ? r_pt_y : r_pt_x;

    assign map_prod  = {7'd0, ax_tiles} * {12'd0, r_tile};
    assign map_sat   = map_prod[MAP_W-1] ? MAP_MAX : map_prod;
    assign target    = {{2{ax_pt[POS_W-1]}}, ax_pt} - {7'd0, ax_screen[CFG_W-1:1]};
    assign diff_calc = {{2{ax_cam[CAM_W-1]}}, ax_cam} - {{3{target[17]}}, target};

    always_comb begin
        if (r_diff > STEP_POS) begin
            step_cl = STEP_MAX;
        end else if (r_diff < STEP_NEG) begin
            step_cl = STEP_MIN;
        end else begin
            step_cl = r_diff[4:0];
        end
    end

    assign hi_mag    = -r_hi;
    assign small_cam = -(hi_mag >>> 1);

    always_comb begin
        if (r_hi[SUM_W-1]) begin
            cam_new = small_cam[CAM_W-1:0];
        end else if (r_cand > r_hi) begin
            cam_new = r_hi[CAM_W-1:0];
        end else if (r_cand[SUM_W-1]) begin
            cam_new = '0;
        end else begin
            cam_new = r_cand[CAM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_screen_w  <= RST_SCREEN_W;
            r_screen_h  <= RST_SCREEN_H;
            r_map_w     <= RST_MAP_W;
            r_map_h     <= RST_MAP_H;
            r_tile      <= RST_TILE;
            r_single    <= 1'b0;
            r_ref_x     <= '0;
            r_ref_y     <= '0;
            r_tracked   <= '0;
            r_seen      <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_count     <= '0;
            r_cam_x     <= '0;
            r_cam_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_SCREEN_W:     r_screen_w <= i_cfg_data;
                    CFG_SCREEN_H:     r_screen_h <= i_cfg_data;
                    CFG_MAP_W:        r_map_w    <= i_cfg_data;
                    CFG_MAP_H:        r_map_h    <= i_cfg_data;
                    CFG_TILE:         r_tile     <= i_cfg_data[TILE_W-1:0];
                    CFG_TRACK_SINGLE: r_single   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && !i_func && in_range) begin
                        if (i_avatar_index == '0) begin
                            r_ref_x      <= i_pos_x;
                            r_ref_y      <= i_pos_y;
                            r_tracked[0] <= 1'b1;
                            r_sum_x      <= SUM_W'(i_pos_x);
                            r_sum_y      <= SUM_W'(i_pos_y);
                            r_count      <= CNT_W'(1);
                            r_seen       <= SLOTS'(1);
                        end else if (!seen_hit) begin
                            r_seen    <= r_seen | sel;
                            r_tracked <= n_t ? (r_tracked | sel) : (r_tracked & ~sel);
                            if (n_t) begin
                                r_sum_x <= r_sum_x + SUM_W'(i_pos_x);
                                r_sum_y <= r_sum_y + SUM_W'(i_pos_y);
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                    end else if (in_acc && i_func) begin
                        if (r_single || r_count == '0) begin
                            r_state <= S_MAP;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_bit == DIV_CNT_W'(DIV_STEPS - 1) && r_axis) begin
                        r_state <= S_MAP;
                    end
                end
                S_MAP:   r_state <= S_STEP;
                S_STEP:  r_state <= S_CLAMP;
                S_CLAMP: begin
                    if (r_axis) begin
                        r_cam_y <= cam_new;
                        r_state <= S_DONE;
                    end else begin
                        r_cam_x <= cam_new;
                        r_state <= S_MAP;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_sum_x     <= '0;
                        r_sum_y     <= '0;
                        r_count     <= '0;
                        r_seen      <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_axis <= 1'b0;
                r_rem  <= '0;
                r_bit  <= '0;
                r_quo  <= abs_sum_x;
                r_neg  <= r_sum_x[SUM_W-1];
                if (r_single) begin
                    r_pt_x      <= i_pos_x;
                    r_pt_y      <= i_pos_y;
                    r_frame_cnt <= '0;
                end else begin
                    r_pt_x      <= '0;
                    r_pt_y      <= '0;
                    r_frame_cnt <= r_count;
                end
            end
            S_DIV: begin
                if (r_bit == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_bit <= '0;
                    r_rem <= '0;
                    if (r_axis) begin
                        r_pt_y <= pt_div;
                        r_axis <= 1'b0;
                    end else begin
                        r_pt_x <= pt_div;
                        r_quo  <= abs_sum_y;
                        r_neg  <= r_sum_y[SUM_W-1];
                        r_axis <= 1'b1;
                    end
                end else begin
                    r_rem <= div_ge ? div_sub[REM_W-1:0] : div_t[REM_W-1:0];
                    r_quo <= quo_next;
                    r_bit <= r_bit + DIV_CNT_W'(1);
                end
            end
            S_MAP: begin
                r_map  <= map_sat;
                r_diff <= diff_calc;
            end
            S_STEP: begin
                r_cand <= {ax_cam[CAM_W-1], ax_cam} - {{15{step_cl[4]}}, step_cl};
                r_hi   <= {1'b0, r_map} - {8'd0, ax_screen};
            end
            S_CLAMP: begin
                r_axis <= !r_axis;
            end
            S_DONE: begin
                if (out_free) begin
                    r_shift_x <= -r_cam_x;
                    r_shift_y <= -r_cam_y;
                    r_out_cnt <= r_frame_cnt;
                end
            end
            default: ;
        endcase
    end

    a_count_vs_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'($countones(r_seen)))
        else $error("tracked count exceeds slots seen this frame");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the final sequencer step");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_count == '0 && r_seen == '0))
        else $error("frame accumulation not cleared after a frame item");

    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_bit < DIV_CNT_W'(DIV_STEPS) && r_count != '0))
        else $error("divider step out of range or zero divisor");

endmodule

// ===== bench/gtsf_shift_checker.sv =====
`timescale 1ns / 1ps
// Shift checker: tracks the avatar group and camera per accepted item and compares frame results.
// Depends on gtsf_pkg; instantiated beside the block by group_tracking_scroll_follower_tb.
module gtsf_shift_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [gtsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gtsf_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_func,
    input  logic [gtsf_pkg::IDX_W-1:0]          i_avatar_index,
    input  logic signed [gtsf_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [gtsf_pkg::POS_W-1:0]   i_pos_y,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [gtsf_pkg::CAM_W-1:0]   i_shift_x,
    input  logic signed [gtsf_pkg::CAM_W-1:0]   i_shift_y,
    input  logic [gtsf_pkg::CNT_W-1:0]          i_tracked_count,
    output int                                  o_pending,
    output int                                  o_mismatches
);
    import gtsf_pkg::*;

    localparam int NUM_SLOTS  = 8;
    localparam int STEP_LIMIT = 8;
    localparam int LEAVE_DX   = 350;
    localparam int LEAVE_DY   = 250;
    localparam int REJOIN_DX  = 300;
    localparam int REJOIN_DY  = 200;
    localparam int MAP_PX_MAX = 262143;

    typedef struct packed {
        logic signed [CAM_W-1:0] shift_x;
        logic signed [CAM_W-1:0] shift_y;
        logic [CNT_W-1:0]        count;
    } t_frame_shift;

    t_frame_shift frame_shift_q[$];

    int scr_w, scr_h, map_w_tiles, map_h_tiles, tile_px;
    bit follow_single;
    int anchor_x, anchor_y;
    bit [NUM_SLOTS-1:0] in_group, seen_slots;
    int acc_x, acc_y, acc_count;
    int cam_x, cam_y;
    int pending_frames = 0;
    int mismatch_total = 0;

    assign o_pending    = pending_frames;
    assign o_mismatches = mismatch_total;

    task automatic report_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    function automatic int camera_step(int cam, int point, int screen, int tiles, int tile);
        int map_px, target, delta, upper, next;
        map_px = tiles * tile;
        if (map_px > MAP_PX_MAX) map_px = MAP_PX_MAX;
        if (map_px < screen) return -((screen - map_px) / 2);
        target = point - screen / 2;
        delta = cam - target;
        if (delta > STEP_LIMIT) delta = STEP_LIMIT;
        if (delta < -STEP_LIMIT) delta = -STEP_LIMIT;
        next = cam - delta;
        upper = map_px - screen;
        if (next > upper) next = upper;
        if (next < 0) next = 0;
        return next;
    endfunction

    always @(posedge i_clk) begin : track_group
        int px, py, slot, dx, dy, fx, fy, shown;
        bit member;
        t_frame_shift due;
        if (!i_rst_n) begin
            scr_w = RST_SCREEN_W;
            scr_h = RST_SCREEN_H;
            map_w_tiles = RST_MAP_W;
            map_h_tiles = RST_MAP_H;
            tile_px = RST_TILE;
            follow_single = 1'b0;
            anchor_x = 0;
            anchor_y = 0;
            in_group = '0;
            seen_slots = '0;
            acc_x = 0;
            acc_y = 0;
            acc_count = 0;
            cam_x = 0;
            cam_y = 0;
            frame_shift_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frame_shift_q.size() == 0) begin
                    report_mismatch("result with no frame item pending");
                end else begin
                    due = frame_shift_q.pop_front();
                    if (i_shift_x !== due.shift_x)
                        report_mismatch($sformatf("shift_x %0d, want %0d", i_shift_x, due.shift_x));
                    if (i_shift_y !== due.shift_y)
                        report_mismatch($sformatf("shift_y %0d, want %0d", i_shift_y, due.shift_y));
                    if (i_tracked_count !== due.count)
                        report_mismatch($sformatf("tracked_count %0d, want %0d",
                                                  i_tracked_count, due.count));
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCREEN_W:     scr_w = i_cfg_data;
                    CFG_SCREEN_H:     scr_h = i_cfg_data;
                    CFG_MAP_W:        map_w_tiles = i_cfg_data;
                    CFG_MAP_H:        map_h_tiles = i_cfg_data;
                    CFG_TILE:         tile_px = i_cfg_data[TILE_W-1:0];
                    CFG_TRACK_SINGLE: follow_single = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                px = i_pos_x;
                py = i_pos_y;
                slot = i_avatar_index;
                if (!i_func) begin
                    if (slot == 0) begin
                        anchor_x = px;
                        anchor_y = py;
                        in_group[0] = 1'b1;
                        acc_x = px;
                        acc_y = py;
                        acc_count = 1;
                        seen_slots = 1;
                    end else if (!seen_slots[slot]) begin
                        seen_slots[slot] = 1'b1;
                        dx = anchor_x - px;
                        dy = anchor_y - py;
                        if (dx < 0) dx = -dx;
                        if (dy < 0) dy = -dy;
                        member = in_group[slot];
                        if (member && (dx > LEAVE_DX || dy > LEAVE_DY))
                            member = 1'b0;
                        else if (!member && dx < REJOIN_DX && dy < REJOIN_DY)
                            member = 1'b1;
                        in_group[slot] = member;
                        if (member) begin
                            acc_x += px;
                            acc_y += py;
                            acc_count++;
                        end
                    end
                end else begin
                    if (follow_single) begin
                        fx = px;
                        fy = py;
                        shown = 0;
                    end else if (acc_count == 0) begin
                        fx = 0;
                        fy = 0;
                        shown = 0;
                    end else begin
                        fx = acc_x / acc_count;
                        fy = acc_y / acc_count;
                        shown = acc_count;
                    end
                    cam_x = camera_step(cam_x, fx, scr_w, map_w_tiles, tile_px);
                    cam_y = camera_step(cam_y, fy, scr_h, map_h_tiles, tile_px);
                    acc_x = 0;
                    acc_y = 0;
                    acc_count = 0;
                    seen_slots = '0;
                    due.shift_x = CAM_W'(-cam_x);
                    due.shift_y = CAM_W'(-cam_y);
                    due.count = CNT_W'(shown);
                    frame_shift_q.push_back(due);
                end
            end
        end
        pending_frames = frame_shift_q.size();
    end

endmodule

// ===== bench/group_tracking_scroll_follower_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for group_tracking_scroll_follower: drives avatar and frame items, config and stalls.
// Depends on gtsf_pkg, the block and gtsf_shift_checker, which predicts and compares results.
module group_tracking_scroll_follower_tb;
    import gtsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int PHASE_ITEMS    = 206;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_SCREEN_W;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_func = 1'b0;
    logic [IDX_W-1:0]        i_avatar_index = '0;
    logic signed [POS_W-1:0] i_pos_x = '0;
    logic signed [POS_W-1:0] i_pos_y = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [CAM_W-1:0] o_shift_x;
    logic signed [CAM_W-1:0] o_shift_y;
    logic [CNT_W-1:0]        o_tracked_count;

    int frames_pending;
    int mismatches;
    int tx_idle_pct = 18;
    int rx_stall_pct = 65;
    int sent_items = 0;
    int quiet_cycles = 0;
    bit [7:0] sample_seen = '0;

    group_tracking_scroll_follower dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_func(i_func),
        .i_avatar_index(i_avatar_index),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_shift_x(o_shift_x),
        .o_shift_y(o_shift_y),
        .o_tracked_count(o_tracked_count)
    );

    gtsf_shift_checker u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .i_in_stall(o_in_stall),
        .i_func(i_func),
        .i_avatar_index(i_avatar_index),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_shift_x(o_shift_x),
        .i_shift_y(o_shift_y),
        .i_tracked_count(o_tracked_count),
        .o_pending(frames_pending),
        .o_mismatches(mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int any_pos();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic write_reg(t_cfg_idx idx, int value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
    endtask

    task automatic program_view(int sw, int sh, int mw, int mh, int tile, int single);
        write_reg(CFG_SCREEN_W, sw);
        write_reg(CFG_SCREEN_H, sh);
        write_reg(CFG_MAP_W, mw);
        write_reg(CFG_MAP_H, mh);
        write_reg(CFG_TILE, tile);
        write_reg(CFG_TRACK_SINGLE, single);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(bit func, int slot, int x, int y);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= func;
        i_avatar_index <= IDX_W'(slot);
        i_pos_x <= POS_W'(x);
        i_pos_y <= POS_W'(y);
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        if (func || slot == 0 || !sample_seen[slot]) sent_items++;
        if (func) sample_seen = '0;
        else if (slot == 0) sample_seen = 8'b1;
        else sample_seen[slot] = 1'b1;
    endtask

    task automatic settle_block();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (frames_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_traffic(int quota);
        int start, others, base_x, base_y, pick, tmp, slot, x, y;
        int order[7];
        start = sent_items;
        while (sent_items - start < quota) begin
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 4) == 0) begin
                    base_x = any_pos();
                    base_y = any_pos();
                end else begin
                    base_x = int'($urandom_range(0, 40000)) - 20000;
                    base_y = int'($urandom_range(0, 40000)) - 20000;
                end
                send_item(1'b0, 0, base_x, base_y);
                for (int i = 0; i < 7; i++) order[i] = i + 1;
                for (int i = 6; i > 0; i--) begin
                    pick = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[pick];
                    order[pick] = tmp;
                end
                others = $urandom_range(0, 7);
                for (int i = 0; i < others; i++) begin
                    slot = order[i];
                    if ($urandom_range(0, 9) == 0) begin
                        x = any_pos();
                        y = any_pos();
                    end else begin
                        x = base_x + int'($urandom_range(0, 800)) - 400;
                        y = base_y + int'($urandom_range(0, 600)) - 300;
                    end
                    send_item(1'b0, slot, x, y);
                    if (i > 0 && $urandom_range(0, 19) == 0)
                        send_item(1'b0, order[0], any_pos(), any_pos());
                end
                send_item(1'b1, $urandom_range(0, 7), any_pos(), any_pos());
            end else begin
                send_item(1'($urandom_range(0, 1)), $urandom_range(0, 7), any_pos(), any_pos());
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        program_view(320, 240, 40, 30, 16, 0);

        send_item(1'b1, 0, 0, 0);
        send_item(1'b0, 3, 100, 50);
        send_item(1'b1, 5, 1234, -1234);

        send_item(1'b0, 0, 0, 0);
        send_item(1'b0, 1, 299, 199);
        send_item(1'b0, 2, 300, 0);
        send_item(1'b0, 3, 0, 200);
        send_item(1'b0, 1, -5, -5);
        send_item(1'b1, 0, 0, 0);

        send_item(1'b0, 0, 0, 0);
        send_item(1'b0, 1, 350, 250);
        send_item(1'b0, 4, -299, -199);
        send_item(1'b1, 7, -1, -1);

        send_item(1'b0, 0, 0, 0);
        send_item(1'b0, 1, 351, 0);
        send_item(1'b0, 4, 0, -251);
        send_item(1'b0, 5, -32768, 32767);
        send_item(1'b1, 0, 0, 0);

        send_item(1'b0, 0, 32767, -32768);
        send_item(1'b0, 7, 32767, -32768);
        send_item(1'b0, 6, -32768, 32767);
        send_item(1'b0, 2, 32766, -32767);
        send_item(1'b1, 0, 0, 0);

        settle_block();
        program_view(320, 240, 40, 30, 16, 1);
        send_item(1'b1, 0, -32768, 32767);
        send_item(1'b1, 7, 32767, -32768);

        for (int phase = 0; phase < 9; phase++) begin
            settle_block();
            case (phase)
                0: program_view(320, 240, 40, 30, 16, 0);
                1: program_view(1, 1, 4095, 4095, 64, 0);
                2: program_view(4095, 4095, 0, 0, 1, 1);
                4: program_view(200, 100, 30, 20, 8, 1);
                6: program_view(4095, 1, 4095, 0, 64, 0);
                8: program_view(320, 240, 20, 15, 16, 0);
                default: program_view($urandom_range(1, 700), $urandom_range(1, 500),
                                      $urandom_range(0, 60), $urandom_range(0, 60),
                                      $urandom_range(1, 64), $urandom_range(0, 1));
            endcase
            case (phase / 3)
                0: begin
                    tx_idle_pct = 18;
                    rx_stall_pct = 65;
                end
                1: begin
                    tx_idle_pct = 65;
                    rx_stall_pct = 18;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
            endcase
            run_traffic(PHASE_ITEMS);
        end

        settle_block();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
design/gtsf_pkg.sv
design/group_tracking_scroll_follower.sv
bench/gtsf_shift_checker.sv
bench/group_tracking_scroll_follower_tb.sv
